[design/obtm_pkg.sv]
// Shared types, codes and fixed sizes of the object-based transactional memory unit.
package obtm_pkg;

    localparam int OBJECT_COUNT = 256;
    localparam int NUM_TX      = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int TX_W        = 4;
    localparam int OBJ_W       = 8;
    localparam int ID_W        = 5;
    localparam int OWNER_W     = 5;
    localparam int TALLY_W     = 16;

    localparam logic [VALUE_WIDTH-1:0] OBJ_INIT_NEW = VALUE_WIDTH'(100);
    localparam logic [TALLY_W-1:0]     TALLY_MAX    = '1;

    localparam logic [2:0] REQ_BEGIN      = 3'd0;
    localparam logic [2:0] REQ_OPEN_READ  = 3'd1;
    localparam logic [2:0] REQ_OPEN_WRITE = 3'd2;
    localparam logic [2:0] REQ_COMMIT     = 3'd3;
    localparam logic [2:0] REQ_RESTART    = 3'd4;

    localparam logic [1:0] ST_UNUSED    = 2'd0;
    localparam logic [1:0] ST_ACTIVE    = 2'd1;
    localparam logic [1:0] ST_COMMITTED = 2'd2;
    localparam logic [1:0] ST_ABORTED   = 2'd3;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FAIL = 2'd1;
    localparam logic [1:0] STATUS_ERR  = 2'd2;

    localparam logic [OWNER_W-1:0] OWN_COMMITTED = OWNER_W'(NUM_TX);
    localparam logic [OWNER_W-1:0] OWN_ABORTED   = OWNER_W'(NUM_TX + 1);

    typedef struct packed {
        logic [2:0]              req_type;
        logic [TX_W-1:0]         tx_id;
        logic [OBJ_W-1:0]        object_index;
        logic signed [VALUE_WIDTH-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [TX_W-1:0]         granted_id;
        logic signed [VALUE_WIDTH-1:0] read_data;
        logic [1:0]              tx_state;
    } res_t;

    typedef struct packed {
        logic       latch;
        logic       do_begin;
        logic       map_rd_req;
        logic       map_rd_log;
        logic       loc_rd;
        logic       set_loc;
        logic       rlog_wr;
        logic       rlog_rd;
        logic       wlog_rd;
        logic       owner_abort_wr;
        logic       alloc;
        logic       abort_owner;
        logic       set_tgt;
        logic       new_wr;
        logic       idx_clr;
        logic       idx_inc;
        logic       status_en;
        logic [1:0] status_val;
        logic       rd_ok_set;
        logic       tx_set_en;
        logic [1:0] tx_set_val;
        logic       commit_inc;
        logic       restart_fin;
        logic       tsel_owner;
        logic       strobe;
    } cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [1:0] cur_state;
        logic [1:0] own_state;
        logic       own_is_t;
        logic       alloc_full;
        logic       rlog_full;
        logic       tally_above;
        logic       rloop_done;
        logic       wloop_done;
        logic       map_hit;
        logic       took_mismatch;
    } stat_t;

endpackage

[design/obtm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module obtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/obtm_ctrl.sv]
// Request sequencer: decodes a request and steps the datapath through it.
module obtm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  obtm_pkg::stat_t    st,
    output obtm_pkg::cmd_t     cmd,
    output logic               busy
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DEC      = 4'd1;
    localparam logic [3:0] S_RD_MAP   = 4'd2;
    localparam logic [3:0] S_RD_OWN   = 4'd3;
    localparam logic [3:0] S_WR_MAP   = 4'd4;
    localparam logic [3:0] S_WR_OWN   = 4'd5;
    localparam logic [3:0] S_V_START  = 4'd6;
    localparam logic [3:0] S_V_LOG    = 4'd7;
    localparam logic [3:0] S_V_MAP    = 4'd8;
    localparam logic [3:0] S_V_OWN    = 4'd9;
    localparam logic [3:0] S_RS_START = 4'd10;
    localparam logic [3:0] S_RS_LOG   = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    localparam logic [1:0] THEN_READ   = 2'd0;
    localparam logic [1:0] THEN_COMMIT = 2'd1;
    localparam logic [1:0] THEN_WRITE  = 2'd2;

    logic [3:0] state_reg, state_next;
    logic [1:0] then_reg, then_next;
    logic       v_pass, v_fail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            then_reg  <= THEN_READ;
        end
        else
        begin
            state_reg <= state_next;
            then_reg  <= then_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        then_next  = then_reg;
        v_pass     = 1'b0;
        v_fail     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = S_DONE;
                case (st.req_type)
                    obtm_pkg::REQ_BEGIN:
                    begin
                        cmd.do_begin = 1'b1;
                    end
                    obtm_pkg::REQ_RESTART:
                    begin
                        if (st.cur_state != obtm_pkg::ST_ABORTED)
                        begin
                            cmd.status_en  = 1'b1;
                            cmd.status_val = obtm_pkg::STATUS_ERR;
                        end
                        else
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = S_RS_START;
                        end
                    end
                    obtm_pkg::REQ_OPEN_READ, obtm_pkg::REQ_OPEN_WRITE,
                    obtm_pkg::REQ_COMMIT:
                    begin
                        if (st.cur_state == obtm_pkg::ST_ABORTED)
                        begin
                            cmd.status_en  = 1'b1;
                            cmd.status_val = obtm_pkg::STATUS_FAIL;
                        end
                        else if (st.cur_state != obtm_pkg::ST_ACTIVE)
                        begin
                            cmd.status_en  = 1'b1;
                            cmd.status_val = obtm_pkg::STATUS_ERR;
                        end
                        else if (st.req_type == obtm_pkg::REQ_COMMIT)
                        begin
                            cmd.idx_clr = 1'b1;
                            then_next   = THEN_COMMIT;
                            state_next  = S_V_START;
                        end
                        else if (st.req_type == obtm_pkg::REQ_OPEN_READ)
                        begin
                            if (st.rlog_full)
                            begin
                                cmd.status_en  = 1'b1;
                                cmd.status_val = obtm_pkg::STATUS_ERR;
                            end
                            else
                            begin
                                cmd.map_rd_req = 1'b1;
                                state_next     = S_RD_MAP;
                            end
                        end
                        else
                        begin
                            cmd.map_rd_req = 1'b1;
                            state_next     = S_WR_MAP;
                        end
                    end
                    default:
                    begin
                        cmd.status_en  = 1'b1;
                        cmd.status_val = obtm_pkg::STATUS_ERR;
                    end
                endcase
            end
            S_RD_MAP:
            begin
                cmd.loc_rd  = 1'b1;
                cmd.set_loc = 1'b1;
                state_next  = S_RD_OWN;
            end
            S_RD_OWN:
            begin
                cmd.tsel_owner = 1'b1;
                cmd.rlog_wr    = 1'b1;
                cmd.idx_clr    = 1'b1;
                then_next      = THEN_READ;
                state_next     = S_V_START;
            end
            S_WR_MAP:
            begin
                cmd.loc_rd  = 1'b1;
                cmd.set_loc = 1'b1;
                state_next  = S_WR_OWN;
            end
            S_WR_OWN:
            begin
                cmd.tsel_owner = 1'b1;
                if (st.own_is_t)
                begin
                    cmd.set_tgt = 1'b1;
                    cmd.idx_clr = 1'b1;
                    then_next   = THEN_WRITE;
                    state_next  = S_V_START;
                end
                else if (st.alloc_full)
                begin
                    cmd.status_en  = 1'b1;
                    cmd.status_val = obtm_pkg::STATUS_ERR;
                    state_next     = S_DONE;
                end
                else if (st.own_state == obtm_pkg::ST_ACTIVE && !st.tally_above)
                begin
                    cmd.tx_set_en  = 1'b1;
                    cmd.tx_set_val = obtm_pkg::ST_ABORTED;
                    cmd.status_en  = 1'b1;
                    cmd.status_val = obtm_pkg::STATUS_FAIL;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.alloc       = 1'b1;
                    cmd.abort_owner = (st.own_state == obtm_pkg::ST_ACTIVE);
                    cmd.idx_clr     = 1'b1;
                    then_next       = THEN_WRITE;
                    state_next      = S_V_START;
                end
            end
            S_V_START:
            begin
                if (st.rloop_done)
                begin
                    v_pass = 1'b1;
                end
                else
                begin
                    cmd.rlog_rd = 1'b1;
                    state_next  = S_V_LOG;
                end
            end
            S_V_LOG:
            begin
                cmd.map_rd_log = 1'b1;
                state_next     = S_V_MAP;
            end
            S_V_MAP:
            begin
                if (st.map_hit)
                begin
                    cmd.loc_rd = 1'b1;
                    state_next = S_V_OWN;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_V_START;
                end
            end
            S_V_OWN:
            begin
                cmd.tsel_owner = 1'b1;
                if (st.took_mismatch)
                begin
                    v_fail = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_V_START;
                end
            end
            S_RS_START:
            begin
                if (st.wloop_done)
                begin
                    cmd.restart_fin = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.wlog_rd = 1'b1;
                    state_next  = S_RS_LOG;
                end
            end
            S_RS_LOG:
            begin
                cmd.owner_abort_wr = 1'b1;
                cmd.idx_inc        = 1'b1;
                state_next         = S_RS_START;
            end
            S_DONE:
            begin
                cmd.strobe = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (v_pass || v_fail)
        begin
            state_next = S_DONE;
            case (then_reg)
                THEN_READ:
                begin
                    if (v_pass)
                    begin
                        cmd.rd_ok_set = 1'b1;
                    end
                    else
                    begin
                        cmd.status_en  = 1'b1;
                        cmd.status_val = obtm_pkg::STATUS_FAIL;
                    end
                end
                THEN_COMMIT:
                begin
                    cmd.tx_set_en = 1'b1;
                    if (v_pass)
                    begin
                        cmd.tx_set_val = obtm_pkg::ST_COMMITTED;
                        cmd.commit_inc = 1'b1;
                    end
                    else
                    begin
                        cmd.tx_set_val = obtm_pkg::ST_ABORTED;
                        cmd.status_en  = 1'b1;
                        cmd.status_val = obtm_pkg::STATUS_FAIL;
                    end
                end
                default:
                begin
                    if (v_pass)
                    begin
                        cmd.new_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.tx_set_en  = 1'b1;
                        cmd.tx_set_val = obtm_pkg::ST_ABORTED;
                        cmd.status_en  = 1'b1;
                        cmd.status_val = obtm_pkg::STATUS_FAIL;
                    end
                end
            endcase
        end
    end

endmodule

[design/obtm_dp.sv]
// Datapath: transaction table, object map, locator and log memories.
module obtm_dp #(
    parameter int LOCATORS_PER_TX = 32,
    parameter int LOG_DEPTH       = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  obtm_pkg::req_t   req,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata,
    input  obtm_pkg::cmd_t   cmd,
    output obtm_pkg::stat_t  st,
    output obtm_pkg::res_t   result
);

    localparam int NT  = obtm_pkg::NUM_TX;
    localparam int NO  = obtm_pkg::OBJECT_COUNT;
    localparam int VW  = obtm_pkg::VALUE_WIDTH;
    localparam int LW  = $clog2(NT * LOCATORS_PER_TX);
    localparam int GLW = $clog2(NO + NT * LOCATORS_PER_TX);
    localparam int CW  = $clog2(LOG_DEPTH + 1);
    localparam int NFW = $clog2(LOCATORS_PER_TX + 1);
    localparam int LAW = $clog2(NT * LOG_DEPTH);
    localparam int RLW = obtm_pkg::OBJ_W + GLW + 1;

    obtm_pkg::req_t                  req_reg;
    logic [7:0]                      thr_reg;
    logic [obtm_pkg::ID_W-1:0]       id_cnt_reg;
    logic [1:0]                      tx_status_reg [NT];
    logic [NFW-1:0]                  nfl_reg [NT];
    logic [CW-1:0]                   rcnt_reg [NT];
    logic [CW-1:0]                   wcnt_reg [NT];
    logic [obtm_pkg::TALLY_W-1:0]    abort_reg [NT];
    logic [obtm_pkg::TALLY_W-1:0]    commit_reg [NT];
    logic [CW-1:0]                   idx_reg;
    logic [GLW-1:0]                  loc_reg;
    logic [LW-1:0]                   tgt_reg;
    logic                            loc_obj_reg;
    logic [1:0]                      status_reg;
    logic [obtm_pkg::TX_W-1:0]       gid_reg;
    logic                            nost_reg;
    logic [VW-1:0]                   rd_reg;
    logic                            rd_ok_reg;
    logic [NO-1:0]                   map_valid_reg;
    logic                            mv_reg;
    logic [obtm_pkg::OBJ_W-1:0]      mi_reg;

    logic [obtm_pkg::TX_W-1:0]       t;
    logic [GLW-1:0]                  map_q, map_data, nl;
    logic [obtm_pkg::OBJ_W-1:0]      map_raddr;
    logic                            map_re;
    logic [LW-1:0]                   la_new, la_rd;
    logic [obtm_pkg::OWNER_W-1:0]    owner_q, owner_val, owner_wdata;
    logic [LW-1:0]                   owner_waddr, new_waddr;
    logic [VW-1:0]                   old_q, new_q, old_val, new_val, copied, new_wdata;
    logic [1:0]                      tx_rd, own_state;
    logic [obtm_pkg::TX_W-1:0]       tx_raddr;
    logic                            took, begin_ok;
    logic [RLW-1:0]                  rlog_q;
    logic [obtm_pkg::OBJ_W-1:0]      rlog_obj;
    logic [GLW-1:0]                  rlog_loc;
    logic                            rlog_took;
    logic [LW-1:0]                   wlog_q;
    logic [LAW-1:0]                  log_base, log_rptr, rlog_wptr, wlog_wptr;

    assign t         = req_reg.tx_id;
    assign begin_ok  = id_cnt_reg < obtm_pkg::ID_W'(NT);
    assign map_data  = mv_reg ? map_q : GLW'(mi_reg);
    assign la_new    = LW'(LW'(t) * LW'(LOCATORS_PER_TX) + LW'(nfl_reg[t]));
    assign nl        = GLW'(la_new) + GLW'(NO);
    assign la_rd     = LW'(map_data - GLW'(NO));
    assign owner_val = loc_obj_reg ? obtm_pkg::OWN_COMMITTED : owner_q;
    assign tx_raddr  = cmd.tsel_owner ? owner_val[obtm_pkg::TX_W-1:0] : gid_reg;
    assign tx_rd     = tx_status_reg[tx_raddr];
    assign old_val   = loc_obj_reg ? '0 : old_q;
    assign new_val   = loc_obj_reg ? obtm_pkg::OBJ_INIT_NEW : new_q;

    always_comb
    begin
        if (owner_val < obtm_pkg::OWNER_W'(NT))
        begin
            own_state = tx_rd;
        end
        else if (owner_val == obtm_pkg::OWN_ABORTED)
        begin
            own_state = obtm_pkg::ST_ABORTED;
        end
        else
        begin
            own_state = obtm_pkg::ST_COMMITTED;
        end
    end

    assign took   = (own_state == obtm_pkg::ST_COMMITTED);
    assign copied = took ? new_val : old_val;

    assign log_base  = LAW'(LAW'(t) * LAW'(LOG_DEPTH));
    assign log_rptr  = LAW'(log_base + LAW'(idx_reg));
    assign rlog_wptr = LAW'(log_base + LAW'(rcnt_reg[t]));
    assign wlog_wptr = LAW'(log_base + LAW'(wcnt_reg[t]));
    assign {rlog_obj, rlog_loc, rlog_took} = rlog_q;

    assign map_re    = cmd.map_rd_req | cmd.map_rd_log;
    assign map_raddr = cmd.map_rd_log ? rlog_obj : req_reg.object_index;

    assign owner_waddr = cmd.alloc ? la_new : wlog_q;
    assign owner_wdata = cmd.alloc ? obtm_pkg::OWNER_W'(t) : obtm_pkg::OWN_ABORTED;
    assign new_waddr   = cmd.alloc ? la_new : tgt_reg;
    assign new_wdata   = cmd.alloc ? copied : req_reg.write_data;

    obtm_ram #(.WIDTH(GLW), .DEPTH(NO)) u_map (
        .clk(clk), .we(cmd.alloc), .waddr(req_reg.object_index), .wdata(nl),
        .re(map_re), .raddr(map_raddr), .rdata(map_q)
    );

    obtm_ram #(.WIDTH(obtm_pkg::OWNER_W), .DEPTH(NT * LOCATORS_PER_TX)) u_owner (
        .clk(clk), .we(cmd.alloc | cmd.owner_abort_wr), .waddr(owner_waddr),
        .wdata(owner_wdata), .re(cmd.loc_rd), .raddr(la_rd), .rdata(owner_q)
    );

    obtm_ram #(.WIDTH(VW), .DEPTH(NT * LOCATORS_PER_TX)) u_old (
        .clk(clk), .we(cmd.alloc), .waddr(la_new), .wdata(copied),
        .re(cmd.loc_rd), .raddr(la_rd), .rdata(old_q)
    );

    obtm_ram #(.WIDTH(VW), .DEPTH(NT * LOCATORS_PER_TX)) u_new (
        .clk(clk), .we(cmd.alloc | cmd.new_wr), .waddr(new_waddr), .wdata(new_wdata),
        .re(cmd.loc_rd), .raddr(la_rd), .rdata(new_q)
    );

    obtm_ram #(.WIDTH(RLW), .DEPTH(NT * LOG_DEPTH)) u_rlog (
        .clk(clk), .we(cmd.rlog_wr), .waddr(rlog_wptr),
        .wdata({req_reg.object_index, loc_reg, took}),
        .re(cmd.rlog_rd), .raddr(log_rptr), .rdata(rlog_q)
    );

    obtm_ram #(.WIDTH(LW), .DEPTH(NT * LOG_DEPTH)) u_wlog (
        .clk(clk), .we(cmd.alloc), .waddr(wlog_wptr), .wdata(la_new),
        .re(cmd.wlog_rd), .raddr(log_rptr), .rdata(wlog_q)
    );

    // per-transaction table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_cnt_reg    <= '0;
            thr_reg       <= 8'd4;
            map_valid_reg <= '0;
            for (int i = 0; i < NT; i++)
            begin
                tx_status_reg[i] <= obtm_pkg::ST_UNUSED;
                nfl_reg[i]       <= '0;
                rcnt_reg[i]      <= '0;
                wcnt_reg[i]      <= '0;
                abort_reg[i]     <= '0;
                commit_reg[i]    <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (cmd.do_begin && begin_ok)
            begin
                id_cnt_reg <= id_cnt_reg + 1'b1;
                tx_status_reg[id_cnt_reg[obtm_pkg::TX_W-1:0]] <= obtm_pkg::ST_ACTIVE;
                nfl_reg[id_cnt_reg[obtm_pkg::TX_W-1:0]]       <= '0;
                rcnt_reg[id_cnt_reg[obtm_pkg::TX_W-1:0]]      <= '0;
                wcnt_reg[id_cnt_reg[obtm_pkg::TX_W-1:0]]      <= '0;
                abort_reg[id_cnt_reg[obtm_pkg::TX_W-1:0]]     <= '0;
                commit_reg[id_cnt_reg[obtm_pkg::TX_W-1:0]]    <= '0;
            end
            if (cmd.tx_set_en)
            begin
                tx_status_reg[t] <= cmd.tx_set_val;
            end
            if (cmd.abort_owner && owner_val < obtm_pkg::OWNER_W'(NT))
            begin
                tx_status_reg[owner_val[obtm_pkg::TX_W-1:0]] <= obtm_pkg::ST_ABORTED;
            end
            if (cmd.rlog_wr)
            begin
                rcnt_reg[t] <= rcnt_reg[t] + 1'b1;
            end
            if (cmd.alloc)
            begin
                nfl_reg[t]  <= nfl_reg[t] + 1'b1;
                wcnt_reg[t] <= wcnt_reg[t] + 1'b1;
                map_valid_reg[req_reg.object_index] <= 1'b1;
            end
            if (cmd.commit_inc && commit_reg[t] != obtm_pkg::TALLY_MAX)
            begin
                commit_reg[t] <= commit_reg[t] + 1'b1;
            end
            if (cmd.restart_fin)
            begin
                tx_status_reg[t] <= obtm_pkg::ST_ACTIVE;
                rcnt_reg[t]      <= '0;
                wcnt_reg[t]      <= '0;
                if (abort_reg[t] != obtm_pkg::TALLY_MAX)
                begin
                    abort_reg[t] <= abort_reg[t] + 1'b1;
                end
            end
        end
    end

    // request and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg    <= req;
            status_reg <= obtm_pkg::STATUS_OK;
            gid_reg    <= req.tx_id;
            nost_reg   <= 1'b0;
            rd_ok_reg  <= 1'b0;
        end
        if (cmd.do_begin)
        begin
            status_reg <= begin_ok ? obtm_pkg::STATUS_OK : obtm_pkg::STATUS_ERR;
            gid_reg    <= begin_ok ? id_cnt_reg[obtm_pkg::TX_W-1:0] : t;
            nost_reg   <= !begin_ok;
        end
        if (cmd.status_en)
        begin
            status_reg <= cmd.status_val;
        end
        if (cmd.rd_ok_set)
        begin
            rd_ok_reg <= 1'b1;
        end
        if (cmd.rlog_wr)
        begin
            rd_reg <= copied;
        end
        if (cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.set_loc)
        begin
            loc_reg <= map_data;
        end
        if (cmd.loc_rd)
        begin
            loc_obj_reg <= (map_data < GLW'(NO));
        end
        if (cmd.set_tgt)
        begin
            tgt_reg <= LW'(loc_reg - GLW'(NO));
        end
        else if (cmd.alloc)
        begin
            tgt_reg <= la_new;
        end
        if (map_re)
        begin
            mv_reg <= map_valid_reg[map_raddr];
            mi_reg <= map_raddr;
        end
    end

    assign st.req_type      = req_reg.req_type;
    assign st.cur_state     = tx_rd;
    assign st.own_state     = own_state;
    assign st.own_is_t      = !loc_obj_reg && (owner_q == obtm_pkg::OWNER_W'(t));
    assign st.alloc_full    = (wcnt_reg[t] >= CW'(LOG_DEPTH))
                            || (nfl_reg[t] >= NFW'(LOCATORS_PER_TX));
    assign st.rlog_full     = (rcnt_reg[t] >= CW'(LOG_DEPTH));
    assign st.tally_above   = (abort_reg[t] > obtm_pkg::TALLY_W'(thr_reg));
    assign st.rloop_done    = (idx_reg == rcnt_reg[t]);
    assign st.wloop_done    = (idx_reg == wcnt_reg[t]);
    assign st.map_hit       = (map_data == rlog_loc);
    assign st.took_mismatch = (took != rlog_took);

    assign result.status     = status_reg;
    assign result.granted_id = gid_reg;
    assign result.read_data  = rd_ok_reg ? rd_reg : '0;
    assign result.tx_state   = nost_reg ? obtm_pkg::ST_UNUSED : tx_rd;

endmodule

[design/object_based_transactional_memory_unit.sv]
// Top level of the object-based transactional memory unit.
//
// Usage: present a request on req and raise start while busy is low; the
// request is taken at that clock edge and busy rises on the next cycle.
// Exactly one result follows, shown on result for one cycle with valid
// high; it must be captured then, the receiver cannot hold it off. busy
// falls in the cycle after valid, so the next request can be taken then.
// Open_read, open_write and commit walk the read log to validate it: per
// entry one log read, one map read and, when the map still points at the
// logged locator, one locator read. An open_write that stops at the owner
// check skips the walk. Restart walks the write log, marking each locator
// aborted. Begin and requests rejected on decode do neither.
// The user writes backoff_threshold through cfg_we / cfg_wdata only while
// idle; the block itself does not enforce this.
// Reset: all transactions unused, every object on its initial locator
// (value 100), threshold 4; no clearing pass is needed.
module object_based_transactional_memory_unit #(
    parameter int LOCATORS_PER_TX = 32,
    parameter int LOG_DEPTH       = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  obtm_pkg::req_t  req,
    output logic            valid,
    output obtm_pkg::res_t  result,
    input  logic            cfg_we,
    input  logic [7:0]      cfg_wdata
);

    obtm_pkg::cmd_t  cmd;
    obtm_pkg::stat_t st;

    obtm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .st(st), .cmd(cmd), .busy(busy)
    );

    obtm_dp #(.LOCATORS_PER_TX(LOCATORS_PER_TX), .LOG_DEPTH(LOG_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .req(req), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .cmd(cmd), .st(st), .result(result)
    );

    assign valid = cmd.strobe;

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but busy not raised");

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy)
        else $error("result without a request in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (result.status != 2'd3))
        else $error("undefined status code");

endmodule

[test/object_based_transactional_memory_unit_test.sv]
// Self-checking testbench for the object-based transactional memory unit.
`timescale 1ns / 1ps

module object_based_transactional_memory_unit_test;

    localparam int NOBJ        = obtm_pkg::OBJECT_COUNT;
    localparam int NTX         = obtm_pkg::NUM_TX;
    localparam int VW          = obtm_pkg::VALUE_WIDTH;
    localparam int LOC_PER_TX  = 32;
    localparam int LOG_DEPTH   = 32;
    localparam int LOC_TOTAL   = NOBJ + NTX * LOC_PER_TX;
    localparam int IDLE_LIMIT  = 20000;
    localparam int RAND_ITEMS  = 1600;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    obtm_pkg::req_t req = '0;
    logic           valid;
    obtm_pkg::res_t result;
    logic           cfg_we = 1'b0;
    logic [7:0]     cfg_wdata = '0;

    object_based_transactional_memory_unit #(
        .LOCATORS_PER_TX(LOC_PER_TX),
        .LOG_DEPTH(LOG_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .valid(valid),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [7:0]    m_thresh;
    int unsigned   m_next_id;
    logic [1:0]    m_txst [NTX];
    int unsigned   m_map [NOBJ];
    int unsigned   m_owner [LOC_TOTAL];
    logic [VW-1:0] m_old [LOC_TOTAL];
    logic [VW-1:0] m_new [LOC_TOTAL];
    int unsigned   m_nfree [NTX];
    int unsigned   m_robj [NTX][LOG_DEPTH];
    int unsigned   m_rloc [NTX][LOG_DEPTH];
    bit            m_rnew [NTX][LOG_DEPTH];
    int unsigned   m_rcnt [NTX];
    int unsigned   m_wloc [NTX][LOG_DEPTH];
    int unsigned   m_wcnt [NTX];
    int unsigned   m_aborts [NTX];

    obtm_pkg::res_t pending_results [$];
    int unsigned    errors = 0;
    int unsigned    idle_cycles = 0;

    function automatic logic [1:0] owner_state(int unsigned own);
        if (own < NTX)
            return m_txst[own];
        if (own == obtm_pkg::OWN_ABORTED)
            return obtm_pkg::ST_ABORTED;
        return obtm_pkg::ST_COMMITTED;
    endfunction

    function automatic bit read_set_valid(int unsigned t);
        int unsigned ob;
        int unsigned lc;
        for (int i = 0; i < m_rcnt[t]; i++)
        begin
            ob = m_robj[t][i];
            lc = m_rloc[t][i];
            if (m_map[ob] == lc &&
                ((owner_state(m_owner[lc]) == obtm_pkg::ST_COMMITTED) != m_rnew[t][i]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic model_reset();
        m_thresh = 8'd4;
        m_next_id = 0;
        for (int i = 0; i < LOC_TOTAL; i++)
        begin
            m_owner[i] = obtm_pkg::OWN_COMMITTED;
            m_old[i] = '0;
            m_new[i] = (i < NOBJ) ? obtm_pkg::OBJ_INIT_NEW : '0;
        end
        for (int i = 0; i < NOBJ; i++)
            m_map[i] = i;
        for (int i = 0; i < NTX; i++)
        begin
            m_txst[i] = obtm_pkg::ST_UNUSED;
            m_nfree[i] = 0;
            m_rcnt[i] = 0;
            m_wcnt[i] = 0;
            m_aborts[i] = 0;
        end
    endtask

    function automatic logic [1:0] tm_open_read(int unsigned t, int unsigned ob,
                                                output logic [VW-1:0] rd);
        int unsigned lc;
        int unsigned n;
        bit tk;
        rd = '0;
        n = m_rcnt[t];
        if (n >= LOG_DEPTH)
            return obtm_pkg::STATUS_ERR;
        lc = m_map[ob];
        tk = owner_state(m_owner[lc]) == obtm_pkg::ST_COMMITTED;
        m_robj[t][n] = ob;
        m_rloc[t][n] = lc;
        m_rnew[t][n] = tk;
        m_rcnt[t] = n + 1;
        if (!read_set_valid(t))
            return obtm_pkg::STATUS_FAIL;
        rd = tk ? m_new[lc] : m_old[lc];
        return obtm_pkg::STATUS_OK;
    endfunction

    function automatic logic [1:0] tm_open_write(int unsigned t, int unsigned ob,
                                                 logic [VW-1:0] wd);
        int unsigned lc;
        int unsigned own;
        int unsigned nl;
        logic [1:0] ost;
        logic [VW-1:0] copied;
        lc = m_map[ob];
        own = m_owner[lc];
        if (own == t)
        begin
            if (!read_set_valid(t))
            begin
                m_txst[t] = obtm_pkg::ST_ABORTED;
                return obtm_pkg::STATUS_FAIL;
            end
            m_new[lc] = wd;
            return obtm_pkg::STATUS_OK;
        end
        if (m_wcnt[t] >= LOG_DEPTH || m_nfree[t] >= LOC_PER_TX)
            return obtm_pkg::STATUS_ERR;
        ost = owner_state(own);
        if (ost == obtm_pkg::ST_COMMITTED)
            copied = m_new[lc];
        else if (ost == obtm_pkg::ST_ACTIVE)
        begin
            if (m_aborts[t] > m_thresh)
            begin
                if (own < NTX)
                    m_txst[own] = obtm_pkg::ST_ABORTED;
                copied = m_old[lc];
            end
            else
            begin
                m_txst[t] = obtm_pkg::ST_ABORTED;
                return obtm_pkg::STATUS_FAIL;
            end
        end
        else
            copied = m_old[lc];
        nl = NOBJ + t * LOC_PER_TX + m_nfree[t];
        m_nfree[t]++;
        m_owner[nl] = t;
        m_old[nl] = copied;
        m_new[nl] = copied;
        m_map[ob] = nl;
        m_wloc[t][m_wcnt[t]] = nl;
        m_wcnt[t]++;
        if (!read_set_valid(t))
        begin
            m_txst[t] = obtm_pkg::ST_ABORTED;
            return obtm_pkg::STATUS_FAIL;
        end
        m_new[nl] = wd;
        return obtm_pkg::STATUS_OK;
    endfunction

    function automatic obtm_pkg::res_t tm_predict(obtm_pkg::req_t r);
        obtm_pkg::res_t o;
        int unsigned t;
        logic [VW-1:0] rd;
        logic [1:0] cur;
        o = '0;
        rd = '0;
        t = r.tx_id;
        o.granted_id = r.tx_id;
        if (r.req_type == obtm_pkg::REQ_BEGIN)
        begin
            if (m_next_id < NTX)
            begin
                m_nfree[m_next_id] = 0;
                m_rcnt[m_next_id] = 0;
                m_wcnt[m_next_id] = 0;
                m_aborts[m_next_id] = 0;
                m_txst[m_next_id] = obtm_pkg::ST_ACTIVE;
                o.granted_id = obtm_pkg::TX_W'(m_next_id);
                o.tx_state = obtm_pkg::ST_ACTIVE;
                m_next_id++;
            end
            else
                o.status = obtm_pkg::STATUS_ERR;
            return o;
        end
        cur = m_txst[t];
        if (r.req_type > obtm_pkg::REQ_RESTART)
            o.status = obtm_pkg::STATUS_ERR;
        else if (r.req_type == obtm_pkg::REQ_RESTART)
        begin
            if (cur != obtm_pkg::ST_ABORTED)
                o.status = obtm_pkg::STATUS_ERR;
            else
            begin
                for (int i = 0; i < m_wcnt[t]; i++)
                    if (m_owner[m_wloc[t][i]] == t)
                        m_owner[m_wloc[t][i]] = obtm_pkg::OWN_ABORTED;
                m_txst[t] = obtm_pkg::ST_ACTIVE;
                m_rcnt[t] = 0;
                m_wcnt[t] = 0;
                if (m_aborts[t] < 65535)
                    m_aborts[t]++;
            end
        end
        else if (cur == obtm_pkg::ST_ABORTED)
            o.status = obtm_pkg::STATUS_FAIL;
        else if (cur != obtm_pkg::ST_ACTIVE)
            o.status = obtm_pkg::STATUS_ERR;
        else if (r.req_type == obtm_pkg::REQ_COMMIT)
        begin
            if (read_set_valid(t))
                m_txst[t] = obtm_pkg::ST_COMMITTED;
            else
            begin
                m_txst[t] = obtm_pkg::ST_ABORTED;
                o.status = obtm_pkg::STATUS_FAIL;
            end
        end
        else if (r.req_type == obtm_pkg::REQ_OPEN_READ)
            o.status = tm_open_read(t, r.object_index, rd);
        else
            o.status = tm_open_write(t, r.object_index, r.write_data);
        o.tx_state = m_txst[t];
        if (o.status == obtm_pkg::STATUS_OK)
            o.read_data = rd;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    // result checking
    always @(posedge clk)
    begin
        obtm_pkg::res_t e;
        if (rst_n && valid)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 64'(result), '0);
            else
            begin
                e = pending_results.pop_front();
                if (result.status !== e.status)
                    report_mismatch("status", 64'(result.status), 64'(e.status));
                if (result.granted_id !== e.granted_id)
                    report_mismatch("granted_id", 64'(result.granted_id),
                                    64'(e.granted_id));
                if (result.read_data !== e.read_data)
                    report_mismatch("read_data", 64'(result.read_data),
                                    64'(e.read_data));
                if (result.tx_state !== e.tx_state)
                    report_mismatch("tx_state", 64'(result.tx_state), 64'(e.tx_state));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || valid)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // called and returning at a falling edge; start stays high across a
    // zero gap and is only taken once busy has dropped
    task automatic send_request(obtm_pkg::req_t r, bit has_want, obtm_pkg::res_t want);
        obtm_pkg::res_t p;
        int unsigned gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        while (busy)
            @(negedge clk);
        p = tm_predict(r);
        if (has_want && p !== want)
            report_mismatch("directed row", 64'(p), 64'(want));
        pending_results.push_back(p);
        req <= r;
        start <= 1'b1;
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_threshold(logic [7:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        m_thresh = v;
    endtask

    function automatic obtm_pkg::req_t mk(logic [2:0] k, int unsigned t, int unsigned ob,
                                          logic [31:0] wd);
        obtm_pkg::req_t r;
        r.req_type = k;
        r.tx_id = obtm_pkg::TX_W'(t);
        r.object_index = obtm_pkg::OBJ_W'(ob);
        r.write_data = wd;
        return r;
    endfunction

    function automatic obtm_pkg::res_t rs(logic [1:0] s, int unsigned g, logic [31:0] d,
                                          logic [1:0] st);
        obtm_pkg::res_t o;
        o.status = s;
        o.granted_id = obtm_pkg::TX_W'(g);
        o.read_data = d;
        o.tx_state = st;
        return o;
    endfunction

    typedef struct {
        obtm_pkg::req_t r;
        bit             has_want;
        obtm_pkg::res_t want;
    } row_t;

    row_t dir_rows [$];

    function automatic logic [2:0] pick_kind();
        int unsigned x;
        x = $urandom_range(0, 99);
        if (x < 40) return obtm_pkg::REQ_OPEN_READ;
        if (x < 70) return obtm_pkg::REQ_OPEN_WRITE;
        if (x < 82) return obtm_pkg::REQ_COMMIT;
        if (x < 94) return obtm_pkg::REQ_RESTART;
        if (x < 97) return obtm_pkg::REQ_BEGIN;
        return 3'($urandom_range(5, 7));
    endfunction

    initial
    begin
        obtm_pkg::req_t r;
        int unsigned hot;
        model_reset();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        dir_rows = '{
            '{mk(obtm_pkg::REQ_OPEN_READ, 0, 0, 0), 1,
              rs(obtm_pkg::STATUS_ERR, 0, 0, obtm_pkg::ST_UNUSED)},
            '{mk(obtm_pkg::REQ_RESTART, 15, 0, 0), 1,
              rs(obtm_pkg::STATUS_ERR, 15, 0, obtm_pkg::ST_UNUSED)},
            '{mk(obtm_pkg::REQ_BEGIN, 9, 0, 0), 1,
              rs(obtm_pkg::STATUS_OK, 0, 0, obtm_pkg::ST_ACTIVE)},
            '{mk(obtm_pkg::REQ_BEGIN, 0, 0, 0), 1,
              rs(obtm_pkg::STATUS_OK, 1, 0, obtm_pkg::ST_ACTIVE)},
            '{mk(obtm_pkg::REQ_OPEN_READ, 0, 255, 0), 1,
              rs(obtm_pkg::STATUS_OK, 0, 100, obtm_pkg::ST_ACTIVE)},
            '{mk(obtm_pkg::REQ_OPEN_READ, 0, 0, 0), 1,
              rs(obtm_pkg::STATUS_OK, 0, 100, obtm_pkg::ST_ACTIVE)},
            '{mk(3'd7, 0, 0, 0), 1,
              rs(obtm_pkg::STATUS_ERR, 0, 0, obtm_pkg::ST_ACTIVE)},
            '{mk(3'd5, 1, 0, 0), 1,
              rs(obtm_pkg::STATUS_ERR, 1, 0, obtm_pkg::ST_ACTIVE)},
            '{mk(obtm_pkg::REQ_OPEN_WRITE, 1, 0, 32'h7fffffff), 0, '0},
            '{mk(obtm_pkg::REQ_OPEN_WRITE, 1, 0, 32'h80000000), 0, '0},
            '{mk(obtm_pkg::REQ_OPEN_WRITE, 0, 0, 32'hffffffff), 0, '0},
            '{mk(obtm_pkg::REQ_OPEN_READ, 0, 5, 0), 1,
              rs(obtm_pkg::STATUS_FAIL, 0, 0, obtm_pkg::ST_ABORTED)},
            '{mk(obtm_pkg::REQ_COMMIT, 0, 0, 0), 1,
              rs(obtm_pkg::STATUS_FAIL, 0, 0, obtm_pkg::ST_ABORTED)},
            '{mk(obtm_pkg::REQ_RESTART, 0, 0, 0), 1,
              rs(obtm_pkg::STATUS_OK, 0, 0, obtm_pkg::ST_ACTIVE)},
            '{mk(obtm_pkg::REQ_RESTART, 1, 0, 0), 1,
              rs(obtm_pkg::STATUS_ERR, 1, 0, obtm_pkg::ST_ACTIVE)},
            '{mk(obtm_pkg::REQ_OPEN_READ, 1, 0, 0), 0, '0},
            '{mk(obtm_pkg::REQ_COMMIT, 1, 0, 0), 0, '0},
            '{mk(obtm_pkg::REQ_COMMIT, 1, 0, 0), 1,
              rs(obtm_pkg::STATUS_ERR, 1, 0, obtm_pkg::ST_COMMITTED)},
            '{mk(obtm_pkg::REQ_OPEN_READ, 0, 0, 0), 0, '0},
            '{mk(obtm_pkg::REQ_COMMIT, 0, 0, 0), 0, '0}
        };
        foreach (dir_rows[i])
            send_request(dir_rows[i].r, dir_rows[i].has_want, dir_rows[i].want);

        write_threshold(8'd0);
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == 400)
                write_threshold(8'd255);
            else if (i == 800)
                write_threshold(8'($urandom_range(1, 3)));
            else if (i == 1200)
                write_threshold(8'd0);
            // a few hot objects breed conflicts, logs fill up on long runs
            hot = $urandom_range(0, 7);
            r.req_type = pick_kind();
            if (m_next_id < NTX && $urandom_range(0, 60) == 0)
                r.req_type = obtm_pkg::REQ_BEGIN;
            r.tx_id = ($urandom_range(0, 9) == 0) ? obtm_pkg::TX_W'($urandom)
                    : obtm_pkg::TX_W'($urandom_range(0, (m_next_id > 0) ? m_next_id - 1 : 0));
            r.object_index = ($urandom_range(0, 3) == 0) ? obtm_pkg::OBJ_W'($urandom)
                           : obtm_pkg::OBJ_W'(hot);
            r.write_data = $urandom;
            send_request(r, 1'b0, '0);
        end

        drain();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
